/* hw/rtl/ps2_mouse_packet_cursor_tracker_top_macros.svh */
// assertion macros for the ps2 mouse cursor tracker
// used by the rtl files that carry concurrent checks, no other dependencies
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PS2M_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ps2m check failed");

// next-cycle implication, disabled during reset
`define PS2M_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ps2m check failed");

`endif

/* hw/rtl/ps2m_pkg.sv */
// shared types and constants for the ps2 mouse cursor tracker
// no dependencies
package ps2m_pkg;

	// coordinate storage width default
	localparam int COORD_BITS_DEF = 12;

	// fixed field widths
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_COORD_W = 12;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	// register reset values
	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

	// nominal cursor reset position, limited to the coordinate range
	localparam int POS_X_RST_NOM = 512;
	localparam int POS_Y_RST_NOM = 384;

	// header byte bits
	localparam logic [7:0] HDR_SYNC_BIT   = 8'h08;
	localparam logic [7:0] BTN_LEFT_BIT   = 8'h01;
	localparam logic [7:0] BTN_RIGHT_BIT  = 8'h02;
	localparam logic [7:0] BTN_MIDDLE_BIT = 8'h04;

	// input item
	typedef struct packed {
		logic       from_aux;
		logic [7:0] data_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [OUT_COORD_W-1:0] cursor_x;
		logic [OUT_COORD_W-1:0] cursor_y;
		logic                   left_pressed;
		logic                   right_pressed;
		logic                   middle_pressed;
		logic                   packet_done;
		logic                   sync_dropped;
	} out_item_t;

endpackage

/* hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv */
// PS/2 mouse cursor tracker: takes one controller byte per item and returns one result item
// per byte with the clamped cursor position, the buttons of the last full packet and the
// packet-done and sync-dropped flags. An item is caught in an input register when accepted and
// its result is loaded into the result register once that register is empty or taken, and
// is presented from there. One item is accepted every cycle while results are taken; the
// result register stalling is what holds back the input side. Screen size registers are
// written through cfg_we, cfg_index and cfg_data.
// Depends on ps2m_pkg, ps2m_cfg_regs, ps2m_core and the assertion macro header.
`include "ps2_mouse_packet_cursor_tracker_top_macros.svh"

module ps2_mouse_packet_cursor_tracker_top #(
	parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ps2m_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ps2m_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ps2m_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ps2m_pkg::out_item_t            out_item
);
	import ps2m_pkg::*;

	logic                  valid_s1;
	in_item_t              item_s1;
	logic                  valid_s2;
	out_item_t             item_s2;
	logic                  adv_s2;
	logic                  step;
	logic [COORD_BITS-1:0] x_lim;
	logic [COORD_BITS-1:0] y_lim;
	out_item_t             res;

	// flow control: result register frees when empty or taken
	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign step     = valid_s1 && adv_s2;

	ps2m_cfg_regs #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.x_lim    (x_lim),
		.y_lim    (y_lim)
	);

	ps2m_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.item  (item_s1),
		.x_lim (x_lim),
		.y_lim (y_lim),
		.res   (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) item_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// one byte cannot both finish a packet and be dropped as a bad header
	`PS2M_ASSERT_IMP(a_flags_excl, clk, arst_n, valid_s2,
		!(item_s2.packet_done && item_s2.sync_dropped))

	// a byte from the keyboard side raises no flag
	`PS2M_ASSERT_NXT(a_nonaux_quiet, clk, arst_n, step && !item_s1.from_aux,
		!item_s2.packet_done && !item_s2.sync_dropped)

	// buttons only move on a finished packet
	`PS2M_ASSERT_NXT(a_btn_hold, clk, arst_n, step && valid_s2,
		item_s2.packet_done ||
		(item_s2.left_pressed == $past(item_s2.left_pressed) &&
		 item_s2.right_pressed == $past(item_s2.right_pressed) &&
		 item_s2.middle_pressed == $past(item_s2.middle_pressed)))

endmodule

/* hw/rtl/ps2m_cfg_regs.sv */
// screen size registers and the derived cursor limits
// depends on ps2m_pkg
module ps2m_cfg_regs #(
	parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ps2m_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ps2m_pkg::CFG_W-1:0]     cfg_data,
	output logic [COORD_BITS-1:0]          x_lim,
	output logic [COORD_BITS-1:0]          y_lim
);
	import ps2m_pkg::*;

	localparam int EW = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;
	localparam logic [EW-1:0] SPAN = EW'(1) << COORD_BITS;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [EW-1:0]    w_eff;
	logic [EW-1:0]    h_eff;
	logic [EW-1:0]    w_m1;
	logic [EW-1:0]    h_m1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective size: zero acts as one, capped at the coordinate span
	always_comb begin
		w_eff = EW'(width_q);
		if (width_q == '0) w_eff = EW'(1);
		else if (w_eff > SPAN) w_eff = SPAN;
		h_eff = EW'(height_q);
		if (height_q == '0) h_eff = EW'(1);
		else if (h_eff > SPAN) h_eff = SPAN;
		w_m1 = w_eff - EW'(1);
		h_m1 = h_eff - EW'(1);
	end

	assign x_lim = w_m1[COORD_BITS-1:0];
	assign y_lim = h_m1[COORD_BITS-1:0];

endmodule

/* hw/rtl/ps2m_core.sv */
// packet framing, button latch and clamped cursor update
// depends on ps2m_pkg
module ps2m_core #(
	parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ps2m_pkg::in_item_t    item,
	input  logic [COORD_BITS-1:0] x_lim,
	input  logic [COORD_BITS-1:0] y_lim,
	output ps2m_pkg::out_item_t   res
);
	import ps2m_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DX,
		PH_DY
	} phase_t;

	localparam int SW  = COORD_BITS + 2;
	localparam int TOP = (1 << COORD_BITS) - 1;
	localparam int WB  = (COORD_BITS > OUT_COORD_W) ? COORD_BITS : OUT_COORD_W;
	localparam logic [COORD_BITS-1:0] POS_X_RST =
		(POS_X_RST_NOM > TOP) ? COORD_BITS'(TOP) : COORD_BITS'(POS_X_RST_NOM);
	localparam logic [COORD_BITS-1:0] POS_Y_RST =
		(POS_Y_RST_NOM > TOP) ? COORD_BITS'(TOP) : COORD_BITS'(POS_Y_RST_NOM);
	localparam logic [2:0] BTN_MASK = 3'(BTN_LEFT_BIT | BTN_RIGHT_BIT | BTN_MIDDLE_BIT);

	phase_t                phase_q, phase_d;
	logic [2:0]            hdr_btn_q, hdr_btn_d;
	logic [7:0]            dx_q, dx_d;
	logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
	logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
	logic [2:0]            btn_q, btn_d;
	logic                  done;
	logic                  dropped;
	logic signed [SW-1:0]  nx;
	logic signed [SW-1:0]  ny;
	logic [WB-1:0]         xw;
	logic [WB-1:0]         yw;

	// signed move of both axes, y delta subtracted
	assign nx = $signed({2'b00, pos_x_q}) + SW'(signed'(dx_q));
	assign ny = $signed({2'b00, pos_y_q}) - SW'(signed'(item.data_byte));

	// next state for one item
	always_comb begin
		phase_d   = phase_q;
		hdr_btn_d = hdr_btn_q;
		dx_d      = dx_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		btn_d     = btn_q;
		done      = 1'b0;
		dropped   = 1'b0;
		if (item.from_aux) begin
			case (phase_q)
				PH_DX: begin
					dx_d    = item.data_byte;
					phase_d = PH_DY;
				end
				PH_DY: begin
					btn_d = hdr_btn_q & BTN_MASK;
					// clamp to 0..limit
					if (nx[SW-1]) pos_x_d = '0;
					else if (nx > $signed({2'b00, x_lim})) pos_x_d = x_lim;
					else pos_x_d = nx[COORD_BITS-1:0];
					if (ny[SW-1]) pos_y_d = '0;
					else if (ny > $signed({2'b00, y_lim})) pos_y_d = y_lim;
					else pos_y_d = ny[COORD_BITS-1:0];
					phase_d = PH_HEADER;
					done    = 1'b1;
				end
				default: begin
					// header byte; the unused phase code lands here too
					hdr_btn_d = item.data_byte[2:0];
					if ((item.data_byte & HDR_SYNC_BIT) != '0) begin
						phase_d = PH_DX;
					end else begin
						phase_d = PH_HEADER;
						dropped = 1'b1;
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_btn_q <= '0;
			dx_q      <= '0;
			pos_x_q   <= POS_X_RST;
			pos_y_q   <= POS_Y_RST;
			btn_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_btn_q <= hdr_btn_d;
			dx_q      <= dx_d;
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			btn_q     <= btn_d;
		end
	end

	// result reflects state after this item, cursor cut to field width
	assign xw = WB'(pos_x_d);
	assign yw = WB'(pos_y_d);

	always_comb begin
		res.cursor_x       = xw[OUT_COORD_W-1:0];
		res.cursor_y       = yw[OUT_COORD_W-1:0];
		res.left_pressed   = (3'(BTN_LEFT_BIT) & btn_d) != '0;
		res.right_pressed  = (3'(BTN_RIGHT_BIT) & btn_d) != '0;
		res.middle_pressed = (3'(BTN_MIDDLE_BIT) & btn_d) != '0;
		res.packet_done    = done;
		res.sync_dropped   = dropped;
	end

endmodule

/* tb/sv/cursor_tracker_sb_pkg.sv */
// scoreboard for the ps2 mouse cursor tracker: predicts the report for every byte
// taken by the block and checks the reports it returns, in order
// depends on ps2m_pkg
`timescale 1ns / 100ps

package cursor_tracker_sb_pkg;
	import ps2m_pkg::*;

	// packet framing position
	typedef enum logic [1:0] {WAIT_HEADER, WAIT_DX, WAIT_DY} frame_phase_t;

	localparam int COORD_SPAN = 1 << COORD_BITS_DEF;

	class cursor_tracker_sb;
		logic [CFG_W-1:0]          width_reg;
		logic [CFG_W-1:0]          height_reg;
		frame_phase_t              phase;
		logic [7:0]                header;
		logic [7:0]                dx_byte;
		logic [7:0]                held_buttons;
		logic [COORD_BITS_DEF-1:0] pos_x;
		logic [COORD_BITS_DEF-1:0] pos_y;
		out_item_t                 pending_reports[$];
		int unsigned               report_count;
		int unsigned               fail_count;

		function new();
			width_reg = SCREEN_WIDTH_RST;
			height_reg = SCREEN_HEIGHT_RST;
			phase = WAIT_HEADER;
			header = '0;
			dx_byte = '0;
			held_buttons = '0;
			// centre of the reset screen, kept inside the coordinate range
			pos_x = COORD_BITS_DEF'((POS_X_RST_NOM > COORD_SPAN - 1) ?
				COORD_SPAN - 1 : POS_X_RST_NOM);
			pos_y = COORD_BITS_DEF'((POS_Y_RST_NOM > COORD_SPAN - 1) ?
				COORD_SPAN - 1 : POS_Y_RST_NOM);
			report_count = 0;
			fail_count = 0;
		endfunction

		function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_SCREEN_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		// zero size acts as one, oversize acts as the full coordinate span
		function logic [COORD_BITS_DEF-1:0] clamp_to(int v, logic [CFG_W-1:0] size);
			int span;
			span = (size == 0) ? 1 : (size > COORD_SPAN) ? COORD_SPAN : int'(size);
			if (v < 0)
				v = 0;
			if (v > span - 1)
				v = span - 1;
			return v[COORD_BITS_DEF-1:0];
		endfunction

		// advance the packet framing by one byte and queue the report it causes
		function void take_byte(in_item_t it);
			out_item_t rep;
			int        nx;
			int        ny;
			rep = '0;
			if (it.from_aux) begin
				case (phase)
					WAIT_DX: begin
						dx_byte = it.data_byte;
						phase = WAIT_DY;
					end
					WAIT_DY: begin
						nx = int'(pos_x) + int'($signed(dx_byte));
						ny = int'(pos_y) - int'($signed(it.data_byte));
						held_buttons = header & (BTN_LEFT_BIT | BTN_RIGHT_BIT | BTN_MIDDLE_BIT);
						pos_x = clamp_to(nx, width_reg);
						pos_y = clamp_to(ny, height_reg);
						phase = WAIT_HEADER;
						rep.packet_done = 1'b1;
					end
					default: begin
						header = it.data_byte;
						if ((it.data_byte & HDR_SYNC_BIT) != 0) begin
							phase = WAIT_DX;
						end else begin
							phase = WAIT_HEADER;
							rep.sync_dropped = 1'b1;
						end
					end
				endcase
			end
			rep.cursor_x = pos_x;
			rep.cursor_y = pos_y;
			rep.left_pressed = (held_buttons & BTN_LEFT_BIT) != 0;
			rep.right_pressed = (held_buttons & BTN_RIGHT_BIT) != 0;
			rep.middle_pressed = (held_buttons & BTN_MIDDLE_BIT) != 0;
			pending_reports.push_back(rep);
		endfunction

		function string show(out_item_t r);
			return $sformatf("x=%0d y=%0d l=%b r=%b m=%b done=%b drop=%b",
				r.cursor_x, r.cursor_y, r.left_pressed, r.right_pressed,
				r.middle_pressed, r.packet_done, r.sync_dropped);
		endfunction

		// only the first few failures are printed
		function void log_failure(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("%s", msg);
		endfunction

		function void check_report(out_item_t got);
			out_item_t want;
			if (pending_reports.size() == 0) begin
				log_failure($sformatf("unexpected result: %s", show(got)));
				return;
			end
			want = pending_reports.pop_front();
			report_count++;
			if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
				got.left_pressed !== want.left_pressed ||
				got.right_pressed !== want.right_pressed ||
				got.middle_pressed !== want.middle_pressed ||
				got.packet_done !== want.packet_done ||
				got.sync_dropped !== want.sync_dropped)
				log_failure($sformatf("result %0d: expected %s, got %s",
					report_count, show(want), show(got)));
		endfunction
	endclass

endpackage

/* tb/sv/tb_top.sv */
// top of the ps2 mouse cursor tracker testbench: clock, reset, byte source,
// result sink with random stalls, screen size writes and the final verdict
// depends on ps2m_pkg, cursor_tracker_sb_pkg and ps2_mouse_packet_cursor_tracker_top
`timescale 1ns / 100ps

module tb_top;
	import ps2m_pkg::*;
	import cursor_tracker_sb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;

	cursor_tracker_sb sb = new();
	int          send_gap_max = 6;
	int          recv_stall_max = 6;
	int          hold_cycles = 0;
	int unsigned aux_sent = 0;
	int unsigned cycle_count = 0;

	ps2_mouse_packet_cursor_tracker_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// result sink: random stall per item, plus one long hold-off on request
	initial begin : result_sink
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				repeat (n) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			n = $urandom_range(0, recv_stall_max);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_report(out_item);
		end
	end

	// offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic aux, input logic [7:0] data);
		int       gap;
		in_item_t it;
		gap = $urandom_range(0, send_gap_max);
		it.from_aux = aux;
		it.data_byte = data;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.take_byte(it);
		if (aux)
			aux_sent++;
	endtask

	// drop valid and wait until every report is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_size(idx, val);
	endtask

	// new screen size while idle; the cursor must stay where it was until the next packet
	task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		settle();
		write_size(REG_SCREEN_WIDTH, w);
		write_size(REG_SCREEN_HEIGHT, h);
		send_byte(1'b0, 8'($urandom));
	endtask

	// deltas lean on the extremes so the cursor keeps hitting the edges
	function automatic logic [7:0] pick_delta();
		case ($urandom_range(0, 11))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly framed packets, some foreign bytes, noise and cut-off packets
	task automatic random_traffic(input int unsigned n_aux);
		int unsigned goal;
		int          r;
		goal = aux_sent + n_aux;
		while (aux_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_byte(1'b1, 8'($urandom) | HDR_SYNC_BIT);
				if ($urandom_range(0, 9) == 0)
					send_byte(1'b0, 8'($urandom));
				send_byte(1'b1, pick_delta());
				if ($urandom_range(0, 9) == 0)
					send_byte(1'b0, 8'($urandom));
				send_byte(1'b1, pick_delta());
			end else if (r < 85) begin
				send_byte(1'b1, 8'($urandom));
			end else if (r < 93) begin
				send_byte(1'b0, 8'($urandom));
			end else begin
				send_byte(1'b1, 8'($urandom) | HDR_SYNC_BIT);
				send_byte(1'b1, pick_delta());
			end
		end
	endtask

	// stimulus
	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// foreign byte, headers without the sync bit
		send_byte(1'b0, 8'hFF);
		send_byte(1'b1, 8'h00);
		send_byte(1'b1, 8'hF7);
		// all buttons, largest right move, largest up-to-down flip, foreign bytes mid-packet
		send_byte(1'b1, 8'hFF);
		send_byte(1'b0, 8'h08);
		send_byte(1'b1, 8'h7F);
		send_byte(1'b0, 8'hAA);
		send_byte(1'b1, 8'h80);
		// no buttons, largest left move
		send_byte(1'b1, 8'h08);
		send_byte(1'b1, 8'h80);
		send_byte(1'b1, 8'h7F);
		// each button alone, small moves both ways
		send_byte(1'b1, 8'h09);
		send_byte(1'b1, 8'h00);
		send_byte(1'b1, 8'h00);
		send_byte(1'b1, 8'h0A);
		send_byte(1'b1, 8'h01);
		send_byte(1'b1, 8'hFF);
		send_byte(1'b1, 8'h0C);
		send_byte(1'b1, 8'hFF);
		send_byte(1'b1, 8'h01);
		// sign, overflow and aux flag bits of the header have no effect
		send_byte(1'b1, 8'hF8);
		send_byte(1'b1, 8'h00);
		send_byte(1'b1, 8'h00);

		random_traffic(300);

		// full span with no idling on either side
		send_gap_max = 0;
		recv_stall_max = 0;
		set_screen(13'd4096, 13'd4096);
		random_traffic(250);
		send_gap_max = 6;
		recv_stall_max = 6;

		set_screen(13'd1, 13'd1);
		random_traffic(100);

		// zero and oversize settings
		set_screen(13'd0, 13'd8191);
		random_traffic(150);

		// long hold-off at the sink while the source keeps pushing
		set_screen(13'd640, 13'd480);
		send_gap_max = 0;
		hold_cycles = 300;
		random_traffic(200);
		send_gap_max = 6;

		// shrink below the cursor, then clamp at both corners
		set_screen(13'd16, 13'd8);
		send_byte(1'b1, 8'h08);
		send_byte(1'b1, 8'h7F);
		send_byte(1'b1, 8'h80);
		send_byte(1'b1, 8'h08);
		send_byte(1'b1, 8'h80);
		send_byte(1'b1, 8'h7F);
		random_traffic(200);

		repeat (3) begin
			set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
			random_traffic(130);
		end

		settle();
		if (sb.fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ps2m_pkg.sv
hw/rtl/ps2m_cfg_regs.sv
hw/rtl/ps2m_core.sv
hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv
tb/sv/cursor_tracker_sb_pkg.sv
tb/sv/tb_top.sv
